[design/lttc_pkg.sv]
// Package for the lidar time-to-collision brake block.
// Holds sizes, register indexes, polynomial constants and state codes.
// No dependencies.
`timescale 1ns / 1ps

package lttc_pkg;

  localparam int COS_TABLE_BITS = 10;
  localparam int TTC_BITS       = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ANGLE_W    = 18;
  localparam int QUOT_W     = 26;   // range*1000*2^16 / 2^16 < 2^26
  localparam int CMP_W      = 33;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HIGH   = 3'd5;

  localparam logic [15:0] RST_THRESHOLD = 16'd1000;
  localparam logic [15:0] RST_START     = 16'h8000;
  localparam logic [13:0] RST_STEP      = 14'd182;
  localparam logic [15:0] RST_MIN_RANGE = 16'd120;
  localparam logic [15:0] RST_WIN_LOW   = 16'hC000;
  localparam logic [15:0] RST_WIN_HIGH  = 16'h4000;

  // table address keeps the top COS_TABLE_BITS of the 16-bit angle
  localparam logic [15:0] COS_ADDR_MASK = 16'hFFFF << (16 - COS_TABLE_BITS);

  // cos polynomial coefficients, Q16
  localparam logic signed [17:0] POLY_C4  = 18'sd60;
  localparam logic signed [17:0] POLY_C3  = 18'sd1367;
  localparam logic signed [17:0] POLY_C2  = 18'sd16625;
  localparam logic signed [17:0] POLY_C1  = 18'sd80852;
  localparam logic signed [17:0] POLY_ONE = 18'sd65536;

  localparam logic [31:0] RATE_FLOOR = 32'd65536;   // 1 mm/s in Q16

  localparam logic [TTC_BITS-1:0] TTC_MAX = '1;
  localparam logic [23:0]         OUT_TTC_MAX = 24'hFFFFFF;

  localparam logic CMD_RAY   = 1'b0;
  localparam logic CMD_SPEED = 1'b1;

  // multiplier sequence steps
  localparam logic [2:0] MS_USQ   = 3'd0;
  localparam logic [2:0] MS_T4    = 3'd1;
  localparam logic [2:0] MS_T3    = 3'd2;
  localparam logic [2:0] MS_T2    = 3'd3;
  localparam logic [2:0] MS_T1    = 3'd4;
  localparam logic [2:0] MS_RATE  = 3'd5;
  localparam logic [2:0] MS_CHECK = 3'd6;

  localparam logic [3:0] DIV_LAST = 4'd12;   // last divider step, 2 quotient bits per step

endpackage

[design/lidar_ttc_emergency_brake.sv]
// Lidar time-to-collision emergency brake, top level.
// One shared 18x18 multiplier for cos and closing rate, then a 2-bit/cycle divider.
// Depends on lttc_pkg.
`timescale 1ns / 1ps

//  channel  | signals                                        | dir
//  ---------+------------------------------------------------+-----
//  in       | in_valid/in_ready, cmd, range_mm, range_bad,   | in
//           | last_ray, speed_mms                            |
//  out      | out_valid/out_ready, filtered_range_mm,        | out
//           | filtered_is_inf, scan_done, brake, min_ttc_ms  |
//  cfg      | cfg_we, cfg_index, cfg_data                    | in
//
// A speed update gives no result. A ray that yields a TTC runs the shared
// multiplier (cos polynomial, then speed*cos), then the divider, then a final
// min-TTC update; a ray with no closing rate skips the divider, and a bad or
// too short ray goes straight to output. in_ready is high only in idle.
// The result sits in an output register; a stalled out_ready holds the block in
// its final step until the register frees up. Reset is synchronous, no clear pass.

module lidar_ttc_emergency_brake (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [15:0]                    range_mm,
  input  logic                           range_bad,
  input  logic                           last_ray,
  input  logic signed [15:0]             speed_mms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    filtered_range_mm,
  output logic                           filtered_is_inf,
  output logic                           scan_done,
  output logic                           brake,
  output logic [23:0]                    min_ttc_ms,
  input  logic                           cfg_we,
  input  logic [lttc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lttc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // configuration
  logic [15:0] thr;
  logic [15:0] start_ang;
  logic [13:0] ang_step;
  logic [15:0] range_floor;
  logic [15:0] win_low;
  logic [15:0] win_high;

  // scan state
  logic signed [15:0]                   fwd_speed;
  logic [lttc_pkg::ANGLE_W-1:0]         ray_angle;
  logic [lttc_pkg::TTC_BITS-1:0]        min_ttc;
  logic                                 brake_flag;

  // sequencer
  logic [2:0]  state;
  logic [2:0]  mstep;
  logic [3:0]  dcnt;

  // per-item registers
  logic [15:0] f_range;
  logic        f_inf;
  logic        last_q;
  logic        cos_neg;
  logic [16:0] u_reg;
  logic [16:0] u2;
  logic signed [35:0] prod;
  logic [31:0] den;
  logic [31:0] rem;
  logic [25:0] nsh;
  logic [lttc_pkg::QUOT_W-1:0] quot;

  // combinational
  logic [lttc_pkg::ANGLE_W-1:0] start_ext;
  logic [lttc_pkg::ANGLE_W-1:0] step_ext;
  logic        in_window;
  logic        ttc_ok;
  logic [15:0] cos_addr;
  logic [13:0] qx;
  logic [14:0] qx_fold;
  logic [25:0] range_k;
  logic signed [17:0] p_hi;
  logic signed [17:0] c_raw;
  logic signed [17:0] c_clamp;
  logic signed [17:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [35:0] mul_p;
  logic signed [35:0] rate;
  logic        rate_pos;
  logic [32:0] ds1;
  logic [32:0] ds2;
  logic [lttc_pkg::TTC_BITS-1:0] ttc_sat;
  logic        out_free;
  logic        brake_now;

  function automatic logic [32:0] div_step(logic [31:0] r, logic b, logic [31:0] d);
    logic [32:0] r2;
    logic [32:0] diff;
    r2   = {r, b};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      return {1'b1, diff[31:0]};
    end
    return {1'b0, r2[31:0]};
  endfunction

  assign start_ext = {{2{start_ang[15]}}, start_ang};
  assign step_ext  = {{4{ang_step[13]}}, ang_step};

  assign in_window = ($signed(ray_angle) >= $signed({{2{win_low[15]}}, win_low})) &&
                     ($signed(ray_angle) <= $signed({{2{win_high[15]}}, win_high}));
  assign ttc_ok = !range_bad && (range_mm >= range_floor);

  assign cos_addr = ray_angle[15:0] & lttc_pkg::COS_ADDR_MASK;
  assign qx       = cos_addr[13:0];
  assign qx_fold  = cos_addr[14] ? (15'd16384 - {1'b0, qx}) : {1'b0, qx};

  // range * 1000 = range*1024 - range*16 - range*8
  assign range_k = {range_mm, 10'b0} - {6'b0, range_mm, 4'b0} - {7'b0, range_mm, 3'b0};

  assign p_hi    = $signed({1'b0, prod[32:16]});
  assign c_raw   = lttc_pkg::POLY_ONE - p_hi;
  assign c_clamp = c_raw[17] ? 18'sd0 : c_raw;

  always_comb begin
    mul_a = $signed({1'b0, u_reg});
    mul_b = $signed({1'b0, u_reg});
    case (mstep)
      lttc_pkg::MS_T4: begin
        mul_a = p_hi;
        mul_b = lttc_pkg::POLY_C4;
      end
      lttc_pkg::MS_T3: begin
        mul_a = $signed({1'b0, u2});
        mul_b = lttc_pkg::POLY_C3 - p_hi;
      end
      lttc_pkg::MS_T2: begin
        mul_a = $signed({1'b0, u2});
        mul_b = lttc_pkg::POLY_C2 - p_hi;
      end
      lttc_pkg::MS_T1: begin
        mul_a = $signed({1'b0, u2});
        mul_b = lttc_pkg::POLY_C1 - p_hi;
      end
      lttc_pkg::MS_RATE: begin
        mul_a = {{2{fwd_speed[15]}}, fwd_speed};
        mul_b = c_clamp;
      end
      default: begin
        mul_a = $signed({1'b0, u_reg});
        mul_b = $signed({1'b0, u_reg});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // quadrants 1 and 2 carry a negative cosine
  assign rate     = cos_neg ? -prod : prod;
  assign rate_pos = !rate[35] && (rate != 36'sd0);

  assign ds1 = div_step(rem, nsh[25], den);
  assign ds2 = div_step(ds1[31:0], nsh[24], den);

  assign ttc_sat = (lttc_pkg::CMP_W'(quot) > lttc_pkg::CMP_W'(lttc_pkg::TTC_MAX)) ?
                   lttc_pkg::TTC_MAX : lttc_pkg::TTC_BITS'(quot);

  assign out_free  = !out_valid || out_ready;
  assign brake_now = lttc_pkg::CMP_W'(min_ttc) <= lttc_pkg::CMP_W'(thr);
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr         <= lttc_pkg::RST_THRESHOLD;
      start_ang   <= lttc_pkg::RST_START;
      ang_step    <= lttc_pkg::RST_STEP;
      range_floor <= lttc_pkg::RST_MIN_RANGE;
      win_low     <= lttc_pkg::RST_WIN_LOW;
      win_high    <= lttc_pkg::RST_WIN_HIGH;
      fwd_speed   <= '0;
      ray_angle   <= {{2{lttc_pkg::RST_START[15]}}, lttc_pkg::RST_START};
      min_ttc     <= lttc_pkg::TTC_MAX;
      brake_flag  <= 1'b0;
      state       <= S_IDLE;
      mstep       <= lttc_pkg::MS_USQ;
      dcnt        <= '0;
      out_valid   <= 1'b0;
    end else begin
      // in S_OUT the new request reloads the register instead
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          lttc_pkg::REG_THRESHOLD: thr <= cfg_data;
          lttc_pkg::REG_START: begin
            start_ang <= cfg_data;
            ray_angle <= {{2{cfg_data[15]}}, cfg_data};
          end
          lttc_pkg::REG_STEP:      ang_step    <= cfg_data[13:0];
          lttc_pkg::REG_MIN_RANGE: range_floor <= cfg_data;
          lttc_pkg::REG_WIN_LOW:   win_low     <= cfg_data;
          lttc_pkg::REG_WIN_HIGH:  win_high    <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (cmd == lttc_pkg::CMD_SPEED) begin
              fwd_speed <= speed_mms;
            end else begin
              f_range <= (in_window && !range_bad) ? range_mm : 16'd0;
              f_inf   <= !(in_window && !range_bad);
              last_q  <= last_ray;
              cos_neg <= cos_addr[15] ^ cos_addr[14];
              u_reg   <= {qx_fold, 2'b0};
              rem     <= {16'b0, range_k[25:10]};
              nsh     <= {range_k[9:0], 16'b0};
              mstep   <= lttc_pkg::MS_USQ;
              state   <= ttc_ok ? S_MUL : S_OUT;
            end
          end
        end
        S_MUL: begin
          prod <= mul_p;
          if (mstep == lttc_pkg::MS_T4) begin
            u2 <= prod[32:16];
          end
          if (mstep == lttc_pkg::MS_CHECK) begin
            den  <= (rate < 36'sd65536) ? lttc_pkg::RATE_FLOOR : rate[31:0];
            dcnt <= '0;
            quot <= '0;
            state <= rate_pos ? S_DIV : S_OUT;
          end else begin
            mstep <= mstep + 3'd1;
          end
        end
        S_DIV: begin
          rem  <= ds2[31:0];
          nsh  <= {nsh[23:0], 2'b0};
          quot <= {quot[lttc_pkg::QUOT_W-3:0], ds1[32], ds2[32]};
          dcnt <= dcnt + 4'd1;
          if (dcnt == lttc_pkg::DIV_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (ttc_sat < min_ttc) begin
            min_ttc <= ttc_sat;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            filtered_range_mm <= f_range;
            filtered_is_inf   <= f_inf;
            scan_done         <= last_q;
            brake             <= last_q ? brake_now : brake_flag;
            min_ttc_ms        <= (lttc_pkg::CMP_W'(min_ttc) >
                                  lttc_pkg::CMP_W'(lttc_pkg::OUT_TTC_MAX)) ?
                                 lttc_pkg::OUT_TTC_MAX : 24'(min_ttc);
            if (last_q) begin
              brake_flag <= brake_now;
              min_ttc    <= lttc_pkg::TTC_MAX;
              ray_angle  <= start_ext;
            end else begin
              ray_angle  <= ray_angle + step_ext;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
